### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every macro samples on clk and is
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/pfn_pkg.sv
package pfn_pkg;

  // Default configuration.
  localparam int COORD_WIDTH_DEF  = 24;
  localparam int NORMAL_FRAC_DEF  = 14;

  // Fixed output format and thresholds.
  localparam int NORMAL_W         = 16;
  localparam int COLLINEAR_SHIFT  = 17;
  localparam int OUT_MAG_MAX      = 32767;

  // Top-level control states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_ROOT,
    S_EMIT
  } state_t;

  // Micro-operations of one trial vertex, in issue order.
  typedef enum logic [4:0] {
    ST_N0A, ST_N0B, ST_N1A, ST_N1B, ST_N2A, ST_N2B,
    ST_A0, ST_A1, ST_A2,
    ST_B0, ST_B1, ST_B2,
    ST_S0, ST_S1, ST_S2,
    ST_D,
    ST_R,
    ST_Q
  } step_t;

  typedef enum logic {
    ALU_MAC,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [1:0] {
    ACC_KEEP,
    ACC_CLEAR,
    ACC_LOAD
  } acc_mode_t;

  typedef struct packed {
    logic      start;
    alu_op_t   op;
    logic      neg;
    logic      shift_up;
    acc_mode_t acc_mode;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

### hw/rtl/pfn_vertex_if.sv
interface pfn_vertex_if #(
  parameter int COORD_WIDTH = pfn_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic signed [COORD_WIDTH-1:0] vertex_z;
  logic                          last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

### hw/rtl/pfn_normal_if.sv
interface pfn_normal_if ();
  logic                                 valid;
  logic                                 ready;
  logic signed [pfn_pkg::NORMAL_W-1:0]  normal_x;
  logic signed [pfn_pkg::NORMAL_W-1:0]  normal_y;
  logic signed [pfn_pkg::NORMAL_W-1:0]  normal_z;
  logic                                 normal_found;

  modport source (output valid, normal_x, normal_y, normal_z, normal_found, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, normal_found, output ready);
endinterface

### hw/rtl/pfn_alu.sv
`include "assert_macros.svh"

// Shared add/subtract unit. A multiply-accumulate runs shift-and-add over the
// multiplier magnitude, one bit a cycle, and stops once no set bits remain.
// A divide is restoring, one quotient bit a cycle, on the accumulator.
module pfn_alu #(
  parameter int COORD_WIDTH      = pfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = pfn_pkg::NORMAL_FRAC_DEF,
  localparam int EW = COORD_WIDTH + 1,
  localparam int NW = 2 * EW,
  localparam int OW = NW + 1,
  localparam int SW = 2 * NW,
  localparam int QW = 2 * NORMAL_FRAC_BITS + 3,
  localparam int AW = 2 * NW + 2 * NORMAL_FRAC_BITS + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  pfn_pkg::alu_ctrl_t  ctrl,
  input  logic signed [OW-1:0] a,
  input  logic signed [OW-1:0] b,
  input  logic signed [AW-1:0] acc_init,
  input  logic [SW-1:0]       dvsr,
  output pfn_pkg::alu_stat_t  stat,
  output logic signed [AW-1:0] acc,
  output logic [QW-1:0]       quot
);

  localparam int RSH = 2 * NORMAL_FRAC_BITS + 2;
  localparam int CW  = $clog2(QW + 1);

  logic                busy;
  logic                done;
  pfn_pkg::alu_op_t    op;
  logic                sub;
  logic [AW-1:0]       mcand;
  logic [OW-1:0]       mplier;
  logic [CW-1:0]       cnt;
  logic [OW-1:0]       a_mag;
  logic [OW-1:0]       b_mag;
  logic                sub_now;
  logic [AW:0]         addend;
  logic [AW:0]         sum;

  // Operand magnitudes; the negated minimum still fits unsigned.
  assign a_mag = a[OW-1] ? OW'(-a) : OW'(a);
  assign b_mag = b[OW-1] ? OW'(-b) : OW'(b);

  // The one adder, one bit wider so that a trial subtract shows its sign.
  assign sub_now = (op == pfn_pkg::ALU_DIV) || sub;
  assign addend  = sub_now ? ~{1'b0, mcand} : {1'b0, mcand};
  assign sum     = {acc[AW-1], acc} + addend + (AW + 1)'(sub_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= pfn_pkg::ALU_MAC;
      sub  <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        op   <= ctrl.op;
        sub  <= ctrl.neg ^ a[OW-1] ^ b[OW-1];
        cnt  <= CW'(QW);
        unique case (ctrl.acc_mode)
          pfn_pkg::ACC_CLEAR: acc <= '0;
          pfn_pkg::ACC_LOAD:  acc <= acc_init;
          default:            acc <= acc;
        endcase
        if (ctrl.op == pfn_pkg::ALU_DIV) begin
          mcand <= AW'(dvsr) << (QW - 1);
          quot  <= '0;
        end else begin
          mcand  <= AW'(a_mag) << (ctrl.shift_up ? RSH : 0);
          mplier <= b_mag;
        end
      end else if (busy) begin
        if (op == pfn_pkg::ALU_DIV) begin
          // Restoring step: keep the difference when it is not negative.
          if (!sum[AW]) begin
            acc <= sum[AW-1:0];
          end
          quot  <= {quot[QW-2:0], ~sum[AW]};
          mcand <= mcand >> 1;
          cnt   <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else if (mplier == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (mplier[0]) begin
            acc <= sum[AW-1:0];
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  `ASSERT_IMPL(a_alu_start_idle, ctrl.start, !busy, "ALU started while busy")

endmodule

### hw/rtl/pfn_root.sv
`include "assert_macros.svh"

// Finds the largest m in [0, 2^F] with (2m-1)^2 <= q, one bit of m a cycle,
// most significant first. This rounds |N| * 2^F / sqrt(S) to nearest.
module pfn_root #(
  parameter int NORMAL_FRAC_BITS = pfn_pkg::NORMAL_FRAC_DEF,
  localparam int F  = NORMAL_FRAC_BITS,
  localparam int QW = 2 * F + 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [QW-1:0] q,
  output logic          done,
  output logic [F:0]    m
);

  localparam int KW = $clog2(F + 1);

  logic              busy;
  logic [KW-1:0]     k;
  logic [QW-1:0]     q_r;
  logic [F:0]        cand;
  logic [F+1:0]      odd;
  logic [2*F+3:0]    sq;
  logic              take;

  // Trial of the current bit.
  assign cand = m | ((F + 1)'(1) << k);
  assign odd  = {cand, 1'b0} - (F + 2)'(1);
  assign sq   = (2 * F + 4)'(odd) * (2 * F + 4)'(odd);
  assign take = (cand <= ((F + 1)'(1) << F)) && (sq <= (2 * F + 4)'(q_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= KW'(F);
        m    <= '0;
        q_r  <= q;
      end else if (busy) begin
        if (take) begin
          m <= cand;
        end
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  `ASSERT_IMPL(a_root_done, done, $past(busy), "Root search finished without running")

endmodule

### hw/rtl/polygon_face_normal.sv
// Face normal of a polygon from a vertex stream. Vertices arrive one per
// transaction as signed Q12.12 coordinates; the transaction that carries
// last_vertex closes the polygon and yields one result: a unit normal in
// signed Q1.14 and normal_found. The first two vertices of a polygon and every
// vertex after a normal was found are taken without a trial. Each other vertex
// is a trial run on one shared shift-and-add unit: 16 multiply-accumulates
// and, when the vertex gives the normal, three more multiply-accumulates and
// three restoring divides, with three root searches on a separate unit. The
// input is not ready while a trial runs. A closing vertex passes through an
// emit state that moves the result into the output register, which holds it
// until taken while the next polygon streams in.
`include "assert_macros.svh"

module polygon_face_normal #(
  parameter int COORD_WIDTH      = pfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = pfn_pkg::NORMAL_FRAC_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pfn_vertex_if.sink    vtx,
  pfn_normal_if.source  nrm
);

  localparam int C  = COORD_WIDTH;
  localparam int F  = NORMAL_FRAC_BITS;
  localparam int EW = C + 1;
  localparam int NW = 2 * EW;
  localparam int OW = NW + 1;
  localparam int SW = 2 * NW;
  localparam int QW = 2 * F + 3;
  localparam int AW = 2 * NW + 2 * F + 2;
  localparam int OUTW = pfn_pkg::NORMAL_W;

  pfn_pkg::state_t    state;
  pfn_pkg::state_t    state_next;
  pfn_pkg::step_t     step;
  logic [1:0]         comp;
  logic [1:0]         points_seen;
  logic               found;
  logic               cur_last;

  logic signed [C-1:0]    p1 [3];
  logic signed [C-1:0]    p2 [3];
  logic signed [EW-1:0]   e1 [3];
  logic signed [EW-1:0]   e2 [3];
  logic signed [NW-1:0]   nv [3];
  logic [NW-1:0]          a_sum;
  logic [NW-1:0]          b_sum;
  logic [SW-1:0]          s_sum;
  logic signed [OUTW-1:0] held [3];

  logic                   out_valid;
  logic signed [OUTW-1:0] out_n [3];
  logic                   out_found;

  pfn_pkg::alu_ctrl_t     alu_ctrl;
  pfn_pkg::alu_stat_t     alu_st;
  logic signed [OW-1:0]   op_a;
  logic signed [OW-1:0]   op_b;
  logic signed [AW-1:0]   acc_init;
  logic [SW-1:0]          dvsr;
  logic signed [AW-1:0]   acc;
  logic [QW-1:0]          quot;

  logic                   root_start;
  logic                   root_done;
  logic [F:0]             root_m;
  logic [OUTW-1:0]        mag;

  logic                   in_take;
  logic                   out_free;
  logic                   trial;
  logic                   step_done;

  assign in_take  = vtx.valid && vtx.ready;
  assign out_free = !out_valid || nrm.ready;
  assign trial    = (points_seen == 2'd2) && !found;
  assign step_done = (state == pfn_pkg::S_WAIT) && alu_st.done;

  // Operand selection for the current micro-operation.
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    alu_ctrl = '{start: 1'b0, op: pfn_pkg::ALU_MAC, neg: 1'b0, shift_up: 1'b0,
                 acc_mode: pfn_pkg::ACC_KEEP};
    unique case (step)
      pfn_pkg::ST_N0A: begin
        op_a = OW'(e1[1]); op_b = OW'(e2[2]); alu_ctrl.acc_mode = pfn_pkg::ACC_CLEAR;
      end
      pfn_pkg::ST_N0B: begin
        op_a = OW'(e1[2]); op_b = OW'(e2[1]); alu_ctrl.neg = 1'b1;
      end
      pfn_pkg::ST_N1A: begin
        op_a = OW'(e1[2]); op_b = OW'(e2[0]); alu_ctrl.acc_mode = pfn_pkg::ACC_CLEAR;
      end
      pfn_pkg::ST_N1B: begin
        op_a = OW'(e1[0]); op_b = OW'(e2[2]); alu_ctrl.neg = 1'b1;
      end
      pfn_pkg::ST_N2A: begin
        op_a = OW'(e1[0]); op_b = OW'(e2[1]); alu_ctrl.acc_mode = pfn_pkg::ACC_CLEAR;
      end
      pfn_pkg::ST_N2B: begin
        op_a = OW'(e1[1]); op_b = OW'(e2[0]); alu_ctrl.neg = 1'b1;
      end
      pfn_pkg::ST_A0: begin
        op_a = OW'(e1[0]); op_b = OW'(e1[0]); alu_ctrl.acc_mode = pfn_pkg::ACC_CLEAR;
      end
      pfn_pkg::ST_A1: begin
        op_a = OW'(e1[1]); op_b = OW'(e1[1]);
      end
      pfn_pkg::ST_A2: begin
        op_a = OW'(e1[2]); op_b = OW'(e1[2]);
      end
      pfn_pkg::ST_B0: begin
        op_a = OW'(e2[0]); op_b = OW'(e2[0]); alu_ctrl.acc_mode = pfn_pkg::ACC_CLEAR;
      end
      pfn_pkg::ST_B1: begin
        op_a = OW'(e2[1]); op_b = OW'(e2[1]);
      end
      pfn_pkg::ST_B2: begin
        op_a = OW'(e2[2]); op_b = OW'(e2[2]);
      end
      pfn_pkg::ST_S0: begin
        op_a = OW'(nv[0]); op_b = OW'(nv[0]); alu_ctrl.acc_mode = pfn_pkg::ACC_CLEAR;
      end
      pfn_pkg::ST_S1: begin
        op_a = OW'(nv[1]); op_b = OW'(nv[1]);
      end
      pfn_pkg::ST_S2: begin
        op_a = OW'(nv[2]); op_b = OW'(nv[2]);
      end
      pfn_pkg::ST_D: begin
        // S * 2^17 - A * B: the edges are not collinear when this is >= 0.
        op_a = signed'(OW'(a_sum)); op_b = signed'(OW'(b_sum));
        alu_ctrl.neg = 1'b1; alu_ctrl.acc_mode = pfn_pkg::ACC_LOAD;
      end
      pfn_pkg::ST_R: begin
        // N_i^2 * 2^(2F+2), the dividend of the rounding test.
        op_a = OW'(nv[comp]); op_b = OW'(nv[comp]);
        alu_ctrl.shift_up = 1'b1; alu_ctrl.acc_mode = pfn_pkg::ACC_CLEAR;
      end
      pfn_pkg::ST_Q: begin
        alu_ctrl.op = pfn_pkg::ALU_DIV;
      end
      default: begin
        op_a = '0;
      end
    endcase
    alu_ctrl.start = (state == pfn_pkg::S_ISSUE);
  end

  assign acc_init = signed'(AW'(s_sum) << pfn_pkg::COLLINEAR_SHIFT);
  assign dvsr     = (s_sum == '0) ? SW'(1) : s_sum;

  pfn_alu #(
    .COORD_WIDTH      (COORD_WIDTH),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_alu (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (alu_ctrl),
    .a        (op_a),
    .b        (op_b),
    .acc_init (acc_init),
    .dvsr     (dvsr),
    .stat     (alu_st),
    .acc      (acc),
    .quot     (quot)
  );

  pfn_root #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .q     (quot),
    .done  (root_done),
    .m     (root_m)
  );

  // Saturate the rounded magnitude to the output range.
  assign mag = ((F + 1 > 15) && (32'(root_m) > 32'(pfn_pkg::OUT_MAG_MAX))) ?
               OUTW'(pfn_pkg::OUT_MAG_MAX) : OUTW'(root_m);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      pfn_pkg::S_IDLE: begin
        if (in_take) begin
          if (trial) begin
            state_next = pfn_pkg::S_ISSUE;
          end else if (vtx.last_vertex) begin
            state_next = pfn_pkg::S_EMIT;
          end
        end
      end
      pfn_pkg::S_ISSUE: begin
        state_next = pfn_pkg::S_WAIT;
      end
      pfn_pkg::S_WAIT: begin
        if (alu_st.done) begin
          if (step == pfn_pkg::ST_Q) begin
            state_next = pfn_pkg::S_ROOT;
          end else if (step == pfn_pkg::ST_D && acc[AW-1]) begin
            state_next = cur_last ? pfn_pkg::S_EMIT : pfn_pkg::S_IDLE;
          end else begin
            state_next = pfn_pkg::S_ISSUE;
          end
        end
      end
      pfn_pkg::S_ROOT: begin
        if (root_done) begin
          if (comp == 2'd2) begin
            state_next = cur_last ? pfn_pkg::S_EMIT : pfn_pkg::S_IDLE;
          end else begin
            state_next = pfn_pkg::S_ISSUE;
          end
        end
      end
      pfn_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = pfn_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pfn_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake and unit start outputs.
  always_comb begin
    vtx.ready  = (state == pfn_pkg::S_IDLE);
    root_start = step_done && (step == pfn_pkg::ST_Q);
  end

  // State, polygon bookkeeping and result capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pfn_pkg::S_IDLE;
      step        <= pfn_pkg::ST_N0A;
      comp        <= '0;
      points_seen <= '0;
      found       <= 1'b0;
      cur_last    <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        held[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (nrm.ready) begin
        out_valid <= 1'b0;
      end

      // Vertex transaction.
      if (in_take) begin
        cur_last <= vtx.last_vertex;
        if (points_seen == 2'd0) begin
          p1[0] <= vtx.vertex_x; p1[1] <= vtx.vertex_y; p1[2] <= vtx.vertex_z;
          points_seen <= 2'd1;
        end else if (points_seen == 2'd1) begin
          p2[0] <= vtx.vertex_x; p2[1] <= vtx.vertex_y; p2[2] <= vtx.vertex_z;
          points_seen <= 2'd2;
        end else if (!found) begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= EW'(p2[i]) - EW'(p1[i]);
          end
          e2[0] <= EW'(vtx.vertex_x) - EW'(p2[0]);
          e2[1] <= EW'(vtx.vertex_y) - EW'(p2[1]);
          e2[2] <= EW'(vtx.vertex_z) - EW'(p2[2]);
          step  <= pfn_pkg::ST_N0A;
          comp  <= '0;
        end
      end

      // Capture at the end of each micro-operation.
      if (step_done) begin
        unique case (step)
          pfn_pkg::ST_N0B: nv[0] <= acc[NW-1:0];
          pfn_pkg::ST_N1B: nv[1] <= acc[NW-1:0];
          pfn_pkg::ST_N2B: nv[2] <= acc[NW-1:0];
          pfn_pkg::ST_A2:  a_sum <= acc[NW-1:0];
          pfn_pkg::ST_B2:  b_sum <= acc[NW-1:0];
          pfn_pkg::ST_S2:  s_sum <= acc[SW-1:0];
          default: begin
          end
        endcase
        if (step != pfn_pkg::ST_Q && step != pfn_pkg::ST_D) begin
          step <= pfn_pkg::step_t'(step + 1'b1);
        end else if (step == pfn_pkg::ST_D && !acc[AW-1]) begin
          step <= pfn_pkg::ST_R;
        end
      end

      // One normal component is done.
      if (state == pfn_pkg::S_ROOT && root_done) begin
        held[comp] <= nv[comp][NW-1] ? -signed'(mag) : signed'(mag);
        if (comp == 2'd2) begin
          found <= 1'b1;
        end else begin
          comp <= comp + 1'b1;
          step <= pfn_pkg::ST_R;
        end
      end

      // Close the polygon into the output register.
      if (state == pfn_pkg::S_EMIT && out_free) begin
        out_valid   <= 1'b1;
        out_found   <= found;
        for (int i = 0; i < 3; i++) begin
          out_n[i] <= held[i];
          held[i]  <= '0;
        end
        points_seen <= '0;
        found       <= 1'b0;
      end
    end
  end

  assign nrm.valid        = out_valid;
  assign nrm.normal_x     = out_n[0];
  assign nrm.normal_y     = out_n[1];
  assign nrm.normal_z     = out_n[2];
  assign nrm.normal_found = out_found;

  `ASSERT_IMPL(a_alu_done_wait, alu_st.done, state == pfn_pkg::S_WAIT, "ALU finished outside a wait")
  `ASSERT_NEXT(a_found_no_trial, in_take && found, state != pfn_pkg::S_ISSUE, "Trial after normal found")

endmodule
